/* src/tmq_pkg.sv */
// Package for the timed message queue: sizes, field widths, operation and
// status codes, and the stored entry type.
// No dependencies.
package tmq_pkg;

    // Queue geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int TIME_W   = 48;
    localparam int TAG_W    = 16;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 3;
    localparam int IN_W     = 88;
    localparam int OUT_W    = 136;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_ENQ   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_POLL  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REM   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_DUE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_QUIT    = 3'd4;

    // One stored message
    typedef struct packed {
        logic [TIME_W-1:0]   due;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

endpackage

/* src/timed_message_queue.sv */
// Timed message queue top level: sequencer, entry memory and output register.
// Depends on tmq_pkg.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one operation per transfer (enqueue,
//   poll, remove by tag, clear). m_tvalid/m_tready/m_tdata return exactly
//   one result per operation, in order. cfg_we/cfg_wdata write quit_mode;
//   write it only while the block is idle.
//   Entries sit in a single-port-read, single-port-write memory kept sorted
//   by due time, index 0 being the head. One entry is read and one written
//   per cycle, so the memory port sets the rate: an enqueue moves each later
//   entry up one place before it writes the new one, a poll that hands out
//   the head moves every remaining entry one place towards the head, and a
//   remove walks every entry; clear, the quit cases, full and empty touch no
//   stored entry. The result is then loaded into the output register.
//   s_tready is high only
//   while no operation is in progress.
//   Reset empties the queue and clears quit_mode; memory contents are not
//   cleared. If the receiver stalls, the result waits in the output register
//   and the next operation may be taken; its result is held back in the
//   sequencer until the output register frees.
module timed_message_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,   // quit_mode
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [1:0] func, [49:2] event_time, [65:50] tag, [81:66] item_handle
    input  logic [tmq_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [2:0] status, [18:3] out_handle, [34:19] out_tag, [82:35] out_time,
    // [130:83] wait_time, [135:131] occupancy
    output logic [tmq_pkg::OUT_W-1:0]  m_tdata
);
    import tmq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ENQ    = 6'b000010,
        S_EINS   = 6'b000100,
        S_PHEAD  = 6'b001000,
        S_PSHIFT = 6'b010000,
        S_REM    = 6'b100000
    } state_t;

    // S_DONE is handled through a separate flag to keep the walk states small
    state_t state_reg, state_next;
    logic   done_reg, done_next;
    logic   quit_reg;
    logic   m_tvalid_reg, m_tvalid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] ins_reg, ins_next;
    logic [CNT_W-1:0] wr_reg, wr_next;

    logic [TIME_W-1:0]   in_time_reg, in_time_next;
    logic [TAG_W-1:0]    in_tag_reg, in_tag_next;
    logic [HANDLE_W-1:0] in_handle_reg, in_handle_next;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    entry_t              res_entry_reg, res_entry_next;
    logic [TIME_W-1:0]   res_wait_reg, res_wait_next;

    logic [OUT_W-1:0] m_tdata_reg;
    logic             out_load;

    // Entry memory
    entry_t           entry_mem [DEPTH];
    entry_t           rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;

    // Shared compare unit and helpers
    logic [CNT_W-1:0] cnt_m1;
    logic [IDX_W-1:0] last_idx;
    logic             time_lt;
    logic             enq_move;
    logic [FUNC_W-1:0] s_func;

    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign last_idx = cnt_m1[IDX_W-1:0];
    assign time_lt  = in_time_reg < rd_data_reg.due;
    assign enq_move = (in_time_reg == '0) || time_lt;
    assign s_func   = s_tdata[1:0];

    assign s_tready = (state_reg == S_IDLE) && !done_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        done_next       = done_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        ins_next        = ins_reg;
        wr_next         = wr_reg;
        in_time_next    = in_time_reg;
        in_tag_next     = in_tag_reg;
        in_handle_next  = in_handle_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        res_wait_next   = res_wait_reg;
        rd_addr         = idx_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = rd_data_reg;
        out_load        = 1'b0;
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        case (state_reg)
            S_IDLE:
            begin
                if (done_reg)
                begin
                    // hand the result over once the output register is free
                    if (!m_tvalid_reg || m_tready)
                    begin
                        out_load      = 1'b1;
                        m_tvalid_next = 1'b1;
                        done_next     = 1'b0;
                    end
                end
                else if (s_tvalid)
                begin
                    in_time_next    = s_tdata[49:2];
                    in_tag_next     = s_tdata[65:50];
                    in_handle_next  = s_tdata[81:66];
                    res_status_next = ST_OK;
                    res_entry_next  = '0;
                    res_wait_next   = '0;
                    case (s_func)
                        FN_ENQ:
                        begin
                            if (quit_reg)
                            begin
                                cnt_next        = '0;
                                res_status_next = ST_QUIT;
                                done_next       = 1'b1;
                            end
                            else if (cnt_reg == CNT_W'(DEPTH))
                            begin
                                res_status_next = ST_FULL;
                                done_next       = 1'b1;
                            end
                            else if (cnt_reg == '0)
                            begin
                                ins_next   = '0;
                                state_next = S_EINS;
                            end
                            else
                            begin
                                idx_next   = last_idx;
                                rd_addr    = last_idx;
                                state_next = S_ENQ;
                            end
                        end
                        FN_POLL:
                        begin
                            if (quit_reg)
                            begin
                                res_status_next = ST_QUIT;
                                done_next       = 1'b1;
                            end
                            else if (cnt_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                rd_addr    = '0;
                                state_next = S_PHEAD;
                            end
                        end
                        FN_REM:
                        begin
                            if (cnt_reg == '0)
                                done_next = 1'b1;
                            else
                            begin
                                rd_addr    = '0;
                                idx_next   = '0;
                                wr_next    = '0;
                                state_next = S_REM;
                            end
                        end
                        default:
                        begin
                            cnt_next  = '0;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // walk from the tail towards the head, moving later entries up
            S_ENQ:
            begin
                if (enq_move)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg + IDX_W'(1);
                    mem_wdata = rd_data_reg;
                    if (idx_reg == '0)
                    begin
                        ins_next   = '0;
                        state_next = S_EINS;
                    end
                    else
                    begin
                        idx_next = idx_reg - IDX_W'(1);
                        rd_addr  = idx_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    ins_next   = idx_reg + IDX_W'(1);
                    state_next = S_EINS;
                end
            end

            // write the new entry into the gap
            S_EINS:
            begin
                mem_we           = 1'b1;
                mem_waddr        = ins_reg;
                mem_wdata.due    = in_time_reg;
                mem_wdata.tag    = in_tag_reg;
                mem_wdata.handle = in_handle_reg;
                cnt_next         = cnt_reg + CNT_W'(1);
                state_next       = S_IDLE;
                done_next        = 1'b1;
            end

            // head check for poll
            S_PHEAD:
            begin
                if (time_lt)
                begin
                    res_status_next = ST_NOT_DUE;
                    res_wait_next   = rd_data_reg.due - in_time_reg;
                    state_next      = S_IDLE;
                    done_next       = 1'b1;
                end
                else
                begin
                    res_entry_next = rd_data_reg;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        cnt_next   = '0;
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        idx_next   = IDX_W'(1);
                        rd_addr    = IDX_W'(1);
                        state_next = S_PSHIFT;
                    end
                end
            end

            // move every remaining entry one place towards the head
            S_PSHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg - IDX_W'(1);
                mem_wdata = rd_data_reg;
                if (idx_reg == last_idx)
                begin
                    cnt_next   = cnt_m1;
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    rd_addr  = idx_reg + IDX_W'(1);
                end
            end

            // compact, keeping entries whose tag differs
            S_REM:
            begin
                if (rd_data_reg.tag != in_tag_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_reg[IDX_W-1:0];
                    mem_wdata = rd_data_reg;
                    wr_next   = wr_reg + CNT_W'(1);
                end
                if (idx_reg == last_idx)
                begin
                    cnt_next   = wr_next;
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    rd_addr  = idx_reg + IDX_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            quit_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
            if (cfg_we)
                quit_reg <= cfg_wdata;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        ins_reg        <= ins_next;
        wr_reg         <= wr_next;
        in_time_reg    <= in_time_next;
        in_tag_reg     <= in_tag_next;
        in_handle_reg  <= in_handle_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        res_wait_reg   <= res_wait_next;
        if (out_load)
            m_tdata_reg <= {cnt_reg, res_wait_reg, res_entry_reg.due,
                            res_entry_reg.tag, res_entry_reg.handle, res_status_reg};
    end

    // Entry memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            entry_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= entry_mem[rd_addr];
    end

endmodule
